@@ rtl/lcdst_pkg.sv @@
`default_nettype none

package lcdst_pkg;

    // Scan geometry
    localparam logic [8:0] DOTS_PER_LINE   = 9'd456;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;
    localparam logic [7:0] VBLANK_LINE     = 8'd144;
    localparam logic [8:0] OAM_SCAN_END    = 9'd80;
    localparam logic [8:0] TRANSFER_END    = 9'd252;

    // Word kinds carried on s_tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // LCD modes as reported in the status register
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // Register map
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    localparam logic [7:0] UNMAPPED_READ = 8'hFF;

    // Bit positions
    localparam int LCDC_ENABLE    = 7;
    localparam int STAT_LYC_FLAG  = 2;
    localparam int STAT_HBLANK_IE = 3;
    localparam int STAT_VBLANK_IE = 4;
    localparam int STAT_OAM_IE    = 5;
    localparam int STAT_LYC_IE    = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  cycles;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_irq;
        logic       stat_irq;
        logic       frame_ready;
        logic       render_start;
        logic [7:0] render_line;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/lcdst_in_stage.sv @@
`default_nettype none

module lcdst_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire lcdst_pkg::item_t s_item,
    input  wire logic            take,
    output logic                 item_valid,
    output lcdst_pkg::item_t     item
);

    logic             valid_reg;
    lcdst_pkg::item_t item_reg;

    // The register may refill in the same cycle as its word moves on.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lcdst_engine.sv @@
`default_nettype none

module lcdst_engine (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire lcdst_pkg::item_t item,
    output lcdst_pkg::result_t    result
);

    logic [7:0] lcd_control_reg, lcd_control_next;
    logic [6:0] status_bits_reg, status_bits_next;
    logic [7:0] scroll_y_reg, scroll_y_next;
    logic [7:0] scroll_x_reg, scroll_x_next;
    logic [7:0] line_number_reg, line_number_next;
    logic [7:0] line_compare_reg, line_compare_next;
    logic [7:0] bg_palette_reg, bg_palette_next;
    logic [7:0] obj_palette_zero_reg, obj_palette_zero_next;
    logic [7:0] obj_palette_one_reg, obj_palette_one_next;
    logic [7:0] window_y_reg, window_y_next;
    logic [7:0] window_x_reg, window_x_next;
    logic [8:0] dot_count_reg, dot_count_next;
    logic [1:0] lcd_mode_reg, lcd_mode_next;

    logic       enabled;
    logic [9:0] dot_sum;
    logic       line_wrap;
    logic [8:0] dot_wrapped;
    logic [8:0] line_inc;
    logic [7:0] tick_line;
    logic       coincide;
    logic [6:0] tick_status;
    logic [1:0] tick_mode;
    logic       lyc_req;
    logic [7:0] read_value;

    assign enabled = lcd_control_reg[lcdst_pkg::LCDC_ENABLE];

    // A tick carries at most 255 dots, so at most one line boundary is crossed.
    always_comb begin
        dot_sum     = {1'b0, dot_count_reg} + {2'b00, item.cycles};
        line_wrap   = dot_sum >= {1'b0, lcdst_pkg::DOTS_PER_LINE};
        dot_wrapped = line_wrap ? 9'(dot_sum - {1'b0, lcdst_pkg::DOTS_PER_LINE})
                                : dot_sum[8:0];
        line_inc    = {1'b0, line_number_reg} + 9'd1;
        if (!line_wrap) begin
            tick_line = line_number_reg;
        end else if (line_inc >= {1'b0, lcdst_pkg::LINES_PER_FRAME}) begin
            tick_line = 8'd0;
        end else begin
            tick_line = line_inc[7:0];
        end

        coincide    = tick_line == line_compare_reg;
        tick_status = status_bits_reg;
        lyc_req     = 1'b0;
        if (line_wrap) begin
            tick_status[lcdst_pkg::STAT_LYC_FLAG] = coincide;
            lyc_req = coincide && status_bits_reg[lcdst_pkg::STAT_LYC_IE];
        end

        if (tick_line >= lcdst_pkg::VBLANK_LINE) begin
            tick_mode = lcdst_pkg::MODE_VBLANK;
        end else if (dot_wrapped < lcdst_pkg::OAM_SCAN_END) begin
            tick_mode = lcdst_pkg::MODE_OAM;
        end else if (dot_wrapped < lcdst_pkg::TRANSFER_END) begin
            tick_mode = lcdst_pkg::MODE_TRANSFER;
        end else begin
            tick_mode = lcdst_pkg::MODE_HBLANK;
        end
    end

    always_comb begin
        case (item.address)
            lcdst_pkg::ADDR_LCDC: read_value = lcd_control_reg;
            lcdst_pkg::ADDR_STAT: read_value = {1'b1, status_bits_reg[6:2], lcd_mode_reg};
            lcdst_pkg::ADDR_SCY:  read_value = scroll_y_reg;
            lcdst_pkg::ADDR_SCX:  read_value = scroll_x_reg;
            lcdst_pkg::ADDR_LY:   read_value = line_number_reg;
            lcdst_pkg::ADDR_LYC:  read_value = line_compare_reg;
            lcdst_pkg::ADDR_BGP:  read_value = bg_palette_reg;
            lcdst_pkg::ADDR_OBP0: read_value = obj_palette_zero_reg;
            lcdst_pkg::ADDR_OBP1: read_value = obj_palette_one_reg;
            lcdst_pkg::ADDR_WY:   read_value = window_y_reg;
            lcdst_pkg::ADDR_WX:   read_value = window_x_reg;
            default:              read_value = lcdst_pkg::UNMAPPED_READ;
        endcase
    end

    always_comb begin
        lcd_control_next      = lcd_control_reg;
        status_bits_next      = status_bits_reg;
        scroll_y_next         = scroll_y_reg;
        scroll_x_next         = scroll_x_reg;
        line_number_next      = line_number_reg;
        line_compare_next     = line_compare_reg;
        bg_palette_next       = bg_palette_reg;
        obj_palette_zero_next = obj_palette_zero_reg;
        obj_palette_one_next  = obj_palette_one_reg;
        window_y_next         = window_y_reg;
        window_x_next         = window_x_reg;
        dot_count_next        = dot_count_reg;
        lcd_mode_next         = lcd_mode_reg;
        result                = '0;

        case (item.command)
            lcdst_pkg::CMD_TICK: begin
                if (enabled) begin
                    dot_count_next   = dot_wrapped;
                    line_number_next = tick_line;
                    status_bits_next = tick_status;
                    lcd_mode_next    = tick_mode;
                    result.stat_irq  = lyc_req;
                    if (tick_mode != lcd_mode_reg) begin
                        case (tick_mode)
                            lcdst_pkg::MODE_OAM: begin
                                if (tick_status[lcdst_pkg::STAT_OAM_IE]) begin
                                    result.stat_irq = 1'b1;
                                end
                            end
                            lcdst_pkg::MODE_TRANSFER: begin
                                result.render_start = 1'b1;
                                result.render_line  = tick_line;
                            end
                            lcdst_pkg::MODE_HBLANK: begin
                                if (tick_status[lcdst_pkg::STAT_HBLANK_IE]) begin
                                    result.stat_irq = 1'b1;
                                end
                            end
                            default: begin
                                result.vblank_irq  = 1'b1;
                                result.frame_ready = 1'b1;
                                if (tick_status[lcdst_pkg::STAT_VBLANK_IE]) begin
                                    result.stat_irq = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            lcdst_pkg::CMD_READ: begin
                result.read_data = read_value;
            end
            lcdst_pkg::CMD_WRITE: begin
                case (item.address)
                    lcdst_pkg::ADDR_LCDC: begin
                        // Switching the panel off parks the scan at line 0, dot 0.
                        if (enabled && !item.write_data[lcdst_pkg::LCDC_ENABLE]) begin
                            line_number_next = 8'd0;
                            dot_count_next   = 9'd0;
                            lcd_mode_next    = lcdst_pkg::MODE_HBLANK;
                        end
                        lcd_control_next = item.write_data;
                    end
                    lcdst_pkg::ADDR_STAT: begin
                        status_bits_next = {item.write_data[6:3],
                                            status_bits_reg[lcdst_pkg::STAT_LYC_FLAG], 2'b00};
                    end
                    lcdst_pkg::ADDR_SCY:  scroll_y_next         = item.write_data;
                    lcdst_pkg::ADDR_SCX:  scroll_x_next         = item.write_data;
                    lcdst_pkg::ADDR_LYC:  line_compare_next     = item.write_data;
                    lcdst_pkg::ADDR_BGP:  bg_palette_next       = item.write_data;
                    lcdst_pkg::ADDR_OBP0: obj_palette_zero_next = item.write_data;
                    lcdst_pkg::ADDR_OBP1: obj_palette_one_next  = item.write_data;
                    lcdst_pkg::ADDR_WY:   window_y_next         = item.write_data;
                    lcdst_pkg::ADDR_WX:   window_x_next         = item.write_data;
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcd_control_reg      <= '0;
            status_bits_reg      <= '0;
            scroll_y_reg         <= '0;
            scroll_x_reg         <= '0;
            line_number_reg      <= '0;
            line_compare_reg     <= '0;
            bg_palette_reg       <= '0;
            obj_palette_zero_reg <= '0;
            obj_palette_one_reg  <= '0;
            window_y_reg         <= '0;
            window_x_reg         <= '0;
            dot_count_reg        <= '0;
            lcd_mode_reg         <= lcdst_pkg::MODE_HBLANK;
        end else if (fire) begin
            lcd_control_reg      <= lcd_control_next;
            status_bits_reg      <= status_bits_next;
            scroll_y_reg         <= scroll_y_next;
            scroll_x_reg         <= scroll_x_next;
            line_number_reg      <= line_number_next;
            line_compare_reg     <= line_compare_next;
            bg_palette_reg       <= bg_palette_next;
            obj_palette_zero_reg <= obj_palette_zero_next;
            obj_palette_one_reg  <= obj_palette_one_next;
            window_y_reg         <= window_y_next;
            window_x_reg         <= window_x_next;
            dot_count_reg        <= dot_count_next;
            lcd_mode_reg         <= lcd_mode_next;
        end
    end

    a_dot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dot_count_reg < lcdst_pkg::DOTS_PER_LINE)
        else $error("dot counter left the line");

    a_line_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_number_reg < lcdst_pkg::LINES_PER_FRAME)
        else $error("line counter left the frame");

    a_render_enters_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.render_start |=> lcd_mode_reg == lcdst_pkg::MODE_TRANSFER)
        else $error("render strobe without entry to transfer mode");

    a_disabled_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command == lcdst_pkg::CMD_TICK && !enabled
        |=> $stable(dot_count_reg) && $stable(line_number_reg) && $stable(lcd_mode_reg))
        else $error("scan moved while the panel is off");

    a_bus_no_events: assert property (@(posedge aclk) disable iff (!aresetn)
        item.command != lcdst_pkg::CMD_TICK
        |-> !result.vblank_irq && !result.stat_irq && !result.render_start)
        else $error("register access raised a scan event");

endmodule

`default_nettype wire

@@ rtl/lcdst_out_stage.sv @@
`default_nettype none

module lcdst_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire lcdst_pkg::result_t result,
    output logic                    free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output lcdst_pkg::result_t      m_result
);

    logic               valid_reg;
    lcdst_pkg::result_t result_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lcd_scan_timing_registers_core.sv @@
// LCD scan timing and register block. Each input word is a dot tick, a
// register read or a register write (kind on s_tuser), and each word gives
// exactly one result word on the m_ side. A word is registered on entry,
// worked on once the output register is free, by the dot and line arithmetic
// and the register decode, and the result lands in an output register; the
// block therefore takes one word every cycle unless m_tready holds it back,
// and m_tvalid rises once a word has passed the entry and output registers.
// The output register lets a new word enter while a finished
// result still waits for m_tready; s_tready falls only when both the entry
// and output registers are full and m_tready is low. While bit 7 of the
// control register is set, a tick advances the dot counter of the 456-dot
// line and the 154-line frame, refreshes the LY=LYC flag on a line change
// and reports the interrupts, frame-ready and render-start pulses that the
// resulting mode change raises. Reads of unmapped addresses return 0xFF.
`default_nettype none

module lcd_scan_timing_registers_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cycles [7:0], address [23:8], write_data [31:24]
    input  wire logic [31:0] s_tdata,
    // command [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data [7:0], vblank_irq [8], stat_irq [9], frame_ready [10],
    // render_start [11], render_line [19:12], zero [23:20]
    output logic [23:0]      m_tdata
);

    lcdst_pkg::item_t   s_item;
    lcdst_pkg::item_t   item;
    lcdst_pkg::result_t result;
    lcdst_pkg::result_t m_result;
    logic               item_valid;
    logic               out_free;
    logic               fire;

    // Unpack the input word into its fields.
    assign s_item.command    = s_tuser;
    assign s_item.cycles     = s_tdata[7:0];
    assign s_item.address    = s_tdata[23:8];
    assign s_item.write_data = s_tdata[31:24];

    // A word is processed when it sits in the entry register and the output
    // register can take its result in the same edge.
    assign fire = item_valid && out_free;

    lcdst_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    lcdst_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    lcdst_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // Pack the result word, highest field first.
    assign m_tdata = {4'b0000,
                      m_result.render_line,
                      m_result.render_start,
                      m_result.frame_ready,
                      m_result.stat_irq,
                      m_result.vblank_irq,
                      m_result.read_data};

endmodule

`default_nettype wire

@@ bench/lcd_scan_timing_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the LCD timing block, keeps its own copy of the
// scan counters and registers, and compares every result word with the
// oldest prediction.
module lcd_scan_timing_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               fault_count,
    output int               waiting,
    output int               results_checked,
    output int               frames_seen
);

    localparam logic [7:0] STAT_WRITE_MASK = 8'h78;

    // Shadow copy of the block's registers and scan position.
    logic [7:0] lcdc, scy, scx, ly, lyc, bgp, obp0, obp1, wy, wx;
    logic [6:0] stat;
    logic [8:0] dot_pos;
    logic [1:0] mode;

    lcdst_pkg::result_t pending_results[$];
    int faults = 0;
    int checked = 0;
    int frames = 0;

    assign fault_count     = faults;
    assign results_checked = checked;
    assign frames_seen     = frames;

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, predicted 0x%0h",
                 $time, field, got, want);
        faults++;
    endtask

    function automatic logic [7:0] register_value(input logic [15:0] addr);
        case (addr)
            lcdst_pkg::ADDR_LCDC: return lcdc;
            lcdst_pkg::ADDR_STAT: return {1'b1, stat[6:2], mode};
            lcdst_pkg::ADDR_SCY:  return scy;
            lcdst_pkg::ADDR_SCX:  return scx;
            lcdst_pkg::ADDR_LY:   return ly;
            lcdst_pkg::ADDR_LYC:  return lyc;
            lcdst_pkg::ADDR_BGP:  return bgp;
            lcdst_pkg::ADDR_OBP0: return obp0;
            lcdst_pkg::ADDR_OBP1: return obp1;
            lcdst_pkg::ADDR_WY:   return wy;
            lcdst_pkg::ADDR_WX:   return wx;
            default:              return lcdst_pkg::UNMAPPED_READ;
        endcase
    endfunction

    function automatic void store_register(input logic [15:0] addr, input logic [7:0] value);
        case (addr)
            lcdst_pkg::ADDR_LCDC: begin
                // Switching the display off parks the scan at the top of the frame.
                if (lcdc[lcdst_pkg::LCDC_ENABLE] && !value[lcdst_pkg::LCDC_ENABLE]) begin
                    ly      = '0;
                    dot_pos = '0;
                    mode    = lcdst_pkg::MODE_HBLANK;
                end
                lcdc = value;
            end
            lcdst_pkg::ADDR_STAT: stat = {value[6:3] & STAT_WRITE_MASK[6:3],
                                          stat[lcdst_pkg::STAT_LYC_FLAG], 2'b00};
            lcdst_pkg::ADDR_SCY:  scy  = value;
            lcdst_pkg::ADDR_SCX:  scx  = value;
            lcdst_pkg::ADDR_LYC:  lyc  = value;
            lcdst_pkg::ADDR_BGP:  bgp  = value;
            lcdst_pkg::ADDR_OBP0: obp0 = value;
            lcdst_pkg::ADDR_OBP1: obp1 = value;
            lcdst_pkg::ADDR_WY:   wy   = value;
            lcdst_pkg::ADDR_WX:   wx   = value;
            default: ;
        endcase
    endfunction

    function automatic lcdst_pkg::result_t predict_word(input logic [1:0] kind,
                                                        input logic [31:0] payload);
        lcdst_pkg::result_t r;
        int unsigned        dots;
        logic [1:0]         next_mode;
        r = '0;
        case (kind)
            lcdst_pkg::CMD_READ:  r.read_data = register_value(payload[23:8]);
            lcdst_pkg::CMD_WRITE: store_register(payload[23:8], payload[31:24]);
            lcdst_pkg::CMD_TICK: begin
                if (lcdc[lcdst_pkg::LCDC_ENABLE]) begin
                    dots = dot_pos + payload[7:0];
                    while (dots >= lcdst_pkg::DOTS_PER_LINE) begin
                        dots -= lcdst_pkg::DOTS_PER_LINE;
                        if (ly + 8'd1 >= lcdst_pkg::LINES_PER_FRAME)
                            ly = '0;
                        else
                            ly = ly + 8'd1;
                        if (ly == lyc) begin
                            stat[lcdst_pkg::STAT_LYC_FLAG] = 1'b1;
                            if (stat[lcdst_pkg::STAT_LYC_IE])
                                r.stat_irq = 1'b1;
                        end else begin
                            stat[lcdst_pkg::STAT_LYC_FLAG] = 1'b0;
                        end
                    end
                    dot_pos = dots[8:0];

                    if (ly >= lcdst_pkg::VBLANK_LINE)
                        next_mode = lcdst_pkg::MODE_VBLANK;
                    else if (dot_pos < lcdst_pkg::OAM_SCAN_END)
                        next_mode = lcdst_pkg::MODE_OAM;
                    else if (dot_pos < lcdst_pkg::TRANSFER_END)
                        next_mode = lcdst_pkg::MODE_TRANSFER;
                    else
                        next_mode = lcdst_pkg::MODE_HBLANK;

                    // Only the mode at the end of the tick counts, however many
                    // lines went past in between.
                    if (next_mode != mode) begin
                        mode = next_mode;
                        case (next_mode)
                            lcdst_pkg::MODE_OAM:
                                r.stat_irq = r.stat_irq | stat[lcdst_pkg::STAT_OAM_IE];
                            lcdst_pkg::MODE_HBLANK:
                                r.stat_irq = r.stat_irq | stat[lcdst_pkg::STAT_HBLANK_IE];
                            lcdst_pkg::MODE_TRANSFER: begin
                                r.render_start = 1'b1;
                                r.render_line  = ly;
                            end
                            default: begin
                                r.vblank_irq  = 1'b1;
                                r.frame_ready = 1'b1;
                                r.stat_irq    = r.stat_irq | stat[lcdst_pkg::STAT_VBLANK_IE];
                            end
                        endcase
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        lcdst_pkg::result_t want;
        if (!aresetn) begin
            {lcdc, scy, scx, ly, lyc, bgp, obp0, obp1, wy, wx} = '0;
            stat    = '0;
            dot_pos = '0;
            mode    = lcdst_pkg::MODE_HBLANK;
            pending_results.delete();
            waiting <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked++;
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing predicted", m_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:0] != want.read_data)
                        report_mismatch("read_data", m_tdata[7:0], want.read_data);
                    if (m_tdata[8] != want.vblank_irq)
                        report_mismatch("vblank_irq", m_tdata[8], want.vblank_irq);
                    if (m_tdata[9] != want.stat_irq)
                        report_mismatch("stat_irq", m_tdata[9], want.stat_irq);
                    if (m_tdata[10] != want.frame_ready)
                        report_mismatch("frame_ready", m_tdata[10], want.frame_ready);
                    if (m_tdata[11] != want.render_start)
                        report_mismatch("render_start", m_tdata[11], want.render_start);
                    if (m_tdata[19:12] != want.render_line)
                        report_mismatch("render_line", m_tdata[19:12], want.render_line);
                    if (m_tdata[23:20] != 4'h0)
                        report_mismatch("padding bits", m_tdata[23:20], 0);
                    if (want.frame_ready)
                        frames++;
                end
            end
            // A word taken in at this edge cannot come out at the same edge.
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_word(s_tuser, s_tdata));
            waiting <= pending_results.size();
        end
    end

endmodule

@@ bench/lcd_scan_timing_registers_core_test.sv @@
`timescale 1ns / 100ps

// Top of the bench for the LCD scan timing block. This module only makes
// stimulus and gives the verdict; all prediction and comparison lives in the
// checker instantiated beside the block.
module lcd_scan_timing_registers_core_test;

    // The fourth command code does nothing in the block but must still be sent.
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    // The DMA register address is not decoded by this block.
    localparam logic [15:0] ADDR_DMA   = 16'hFF46;

    localparam int RANDOM_WORDS  = 2000;
    localparam int QUIET_FIRST   = 600;   // no idling on either side between
    localparam int QUIET_LAST    = 900;   // these two word counts
    localparam int HOLD_AT       = 300;   // receiver holds off once here
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_AT      = 1200;  // sender waits for an empty pipe here
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = lcdst_pkg::CMD_TICK;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;

    int fault_count, waiting, results_checked, frames_seen;
    int words_sent = 0;
    int tick_words = 0, read_words = 0, write_words = 0, unused_words = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    wire quiet = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);

    lcd_scan_timing_registers_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lcd_scan_timing_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fault_count     (fault_count),
        .waiting         (waiting),
        .results_checked (results_checked),
        .frames_seen     (frames_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, waiting);
            $display("** lcd_scan_timing_registers_core: FAILED **");
            $finish;
        end
    end

    // Receiver. Once, after HOLD_AT words, it refuses results for a long
    // stretch so that the entry and output registers both fill and s_tready
    // falls while the sender keeps offering. Otherwise it stalls at random,
    // 18 percent of the time, except in the quiet window.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    function automatic logic [31:0] pack_word(input logic [7:0] cycles,
                                              input logic [15:0] address,
                                              input logic [7:0] write_data);
        return {write_data, address, cycles};
    endfunction

    // Register addresses are mostly the decoded window (FF40 to FF4B, which
    // takes in the undecoded FF46), with the odd fully random address.
    function automatic logic [15:0] pick_address();
        if ($urandom_range(0, 99) < 85)
            return lcdst_pkg::ADDR_LCDC + 16'($urandom_range(0, 11));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offers one word, first idling for a random number of cycles, and
    // returns at the edge at which the block accepts it. The ready line is
    // read just after the edge, so it is the value the block saw there.
    task automatic send_word(input logic [1:0] kind, input logic [31:0] payload);
        while (!quiet && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent <= words_sent + 1;
        case (kind)
            lcdst_pkg::CMD_TICK:  tick_words++;
            lcdst_pkg::CMD_READ:  read_words++;
            lcdst_pkg::CMD_WRITE: write_words++;
            default:              unused_words++;
        endcase
    endtask

    initial begin
        logic [1:0]  kind;
        logic [31:0] payload;
        int          pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. With the display off a tick does nothing, and
        // the unused command must come back as an all-zero word.
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'hFF, '0, 8'h00));
        send_word(CMD_UNUSED, '1);
        // Turn every status interrupt on; the line-number write is dropped.
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_STAT, 8'hFF));
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_LY, 8'hFF));
        // Unmapped addresses, including the DMA slot, read as all ones.
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, ADDR_DMA, 8'hFF));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, ADDR_DMA, 8'h00));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, '0, 8'h00));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'hFF, '1, 8'hFF));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_LY, 8'h00));
        // Switch on and walk one line through OAM scan, transfer and hblank,
        // each boundary landing exactly on its dot.
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_LCDC, 8'h80));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd0, '0, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd80, '0, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd172, '0, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd255, '0, 8'h00));
        // Writing the compare register does not refresh the coincidence
        // flag; the next line change does, and raises the LYC interrupt.
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_LYC, 8'h02));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_STAT, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd255, '0, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'd255, '0, 8'h00));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_STAT, 8'h00));
        // Switching off clears line, dot and mode but keeps the flag.
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_LCDC, 8'h00));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_STAT, 8'h00));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_LY, 8'h00));
        send_word(lcdst_pkg::CMD_TICK, pack_word(8'hFF, '0, 8'h00));
        send_word(lcdst_pkg::CMD_WRITE, pack_word(8'h00, lcdst_pkg::ADDR_LCDC, 8'hFF));
        send_word(lcdst_pkg::CMD_READ, pack_word(8'h00, lcdst_pkg::ADDR_LCDC, 8'h00));

        // Random part. Ticks dominate, with many long ones, so that the scan
        // runs through several whole frames; register traffic is mostly to
        // the decoded window, and switching the display off is kept rare.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == DRAIN_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (waiting != 0)
                    @(posedge aclk);
            end
            payload = $urandom();
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                kind = lcdst_pkg::CMD_TICK;
                if ($urandom_range(0, 99) < 60)
                    payload[7:0] = 8'($urandom_range(180, 255));
            end else if (pick < 82) begin
                kind = lcdst_pkg::CMD_READ;
                payload[23:8] = pick_address();
            end else if (pick < 97) begin
                kind = lcdst_pkg::CMD_WRITE;
                payload[23:8] = pick_address();
                if (payload[23:8] == lcdst_pkg::ADDR_LCDC && $urandom_range(0, 99) < 95)
                    payload[24 + lcdst_pkg::LCDC_ENABLE] = 1'b1;
            end else begin
                kind = CMD_UNUSED;
            end
            send_word(kind, payload);
        end
        s_tvalid <= 1'b0;

        // Let every predicted word come back, then give the block a few more
        // cycles in case it produces a word that nobody asked for.
        @(posedge aclk);
        while (waiting != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks, %0d register reads, %0d register writes and %0d unused words;",
                 tick_words, read_words, write_words, unused_words);
        $display("checked %0d result words across %0d completed frames in %0d cycles.",
                 results_checked, frames_seen, cycle_count);
        if (fault_count == 0) begin
            $display("** lcd_scan_timing_registers_core: PASSED **");
        end else begin
            $display("%0d mismatches in total.", fault_count);
            $display("** lcd_scan_timing_registers_core: FAILED **");
        end
        $finish;
    end

endmodule
